// File: rtl/mtrl_pkg.sv
// ----------------------------------------------------------------------------
// mtrl_pkg
// Shared types, constants and helpers of the multibit trie route lookup.
// ----------------------------------------------------------------------------
package mtrl_pkg;

  localparam int DEF_MAX_NODES = 256;
  localparam int LEVELS        = 5;
  localparam int ADDR_W        = 32;
  localparam int GW_W          = 32;
  localparam int PLEN_W        = 6;
  localparam int LVL_W         = 3;
  localparam int SHIFT_W       = 5;
  localparam int IDX_W         = 16;
  localparam int CNT_W         = 17;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_POOL_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } bk_state_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                 cmd;
    logic [ADDR_W-1:0]    addr;
    logic [GW_W-1:0]      gw;
    logic [PLEN_W-1:0]    plen;
    logic [LVL_W-1:0]     tgt;
    logic [SHIFT_W-1:0]   shift;
  } q_word_t;

  function automatic logic [4:0] stride_of(input logic [LVL_W-1:0] l);
    logic [4:0] s;
    unique case (l)
      3'd0:    s = 5'd16;
      3'd1:    s = 5'd8;
      3'd2:    s = 5'd4;
      default: s = 5'd2;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] low_pos(input logic [LVL_W-1:0] l);
    logic [4:0] p;
    unique case (l)
      3'd0:    p = 5'd16;
      3'd1:    p = 5'd8;
      3'd2:    p = 5'd4;
      3'd3:    p = 5'd2;
      default: p = 5'd0;
    endcase
    return p;
  endfunction

  // accumulated stride at the bottom of each level
  function automatic logic [PLEN_W-1:0] level_end(input logic [LVL_W-1:0] l);
    logic [PLEN_W-1:0] e;
    unique case (l)
      3'd0:    e = 6'd16;
      3'd1:    e = 6'd24;
      3'd2:    e = 6'd28;
      3'd3:    e = 6'd30;
      default: e = 6'd32;
    endcase
    return e;
  endfunction

  function automatic logic [IDX_W-1:0] slot_idx(input logic [ADDR_W-1:0] a,
                                                input logic [LVL_W-1:0] l);
    logic [ADDR_W-1:0] sh;
    logic [CNT_W-1:0]  m;
    sh = a >> low_pos(l);
    m  = (CNT_W'(1) << stride_of(l)) - CNT_W'(1);
    return sh[IDX_W-1:0] & m[IDX_W-1:0];
  endfunction

  // 32 minus trailing zeros, 0 for an empty mask
  function automatic logic [PLEN_W-1:0] prefix_len(input logic [ADDR_W-1:0] m);
    logic [PLEN_W-1:0] tz;
    tz = '0;
    for (int i = ADDR_W - 1; i >= 0; i--) begin
      if (m[i]) tz = PLEN_W'(i);
    end
    return (m == '0) ? '0 : PLEN_W'(ADDR_W) - tz;
  endfunction

endpackage

// File: rtl/multibit_trie_route_lookup_top.sv
// ----------------------------------------------------------------------------
// multibit_trie_route_lookup_top
// IPv4 longest prefix match over a five-level multibit trie (16/8/4/2/2).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: cmd, address, mask,
//   gateway. cmd insert adds a route, cmd lookup returns the best gateway.
//   Result channel (out_valid/out_ready) returns one word per input word:
//   next_hop (0 for inserts or no match) and status (1 = node pool full).
//   Lookup: the word is dequeued, then each trie level visited takes a
//   RAM read and then an evaluate step; the chain of dependent slot reads
//   limits lookup speed. Insert: a read and an evaluate step per level
//   walked, then the same pair per slot of the expanded range (up to 65536
//   slots at the root). After reset a clearing pass zeroes all slot RAMs,
//   one address per cycle; in_ready still takes two words into the front
//   queue meanwhile.
//   A stalled receiver holds the result; the front queue keeps accepting
//   until its two entries are full.
// ----------------------------------------------------------------------------
module multibit_trie_route_lookup_top #(
  parameter int MAX_NODES = mtrl_pkg::DEF_MAX_NODES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_address,
  input  logic [31:0] in_mask,
  input  logic [31:0] in_gateway,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_hop,
  output logic        out_status
);

  // classified word queue between front and back
  logic              q_valid;
  logic              q_pop;
  mtrl_pkg::q_word_t q_word;

  mtrl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_address (in_address),
    .in_mask    (in_mask),
    .in_gateway (in_gateway),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .q_pop      (q_pop)
  );

  // back end owns the slot RAMs, node pools and the result register
  mtrl_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_next_hop (out_next_hop),
    .out_status   (out_status)
  );

endmodule

// File: rtl/mtrl_ram.sv
// ----------------------------------------------------------------------------
// mtrl_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtrl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata_r
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we && ({1'b0, waddr} < (AW+1)'(DEPTH))) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

endmodule

// File: rtl/mtrl_front.sv
// ----------------------------------------------------------------------------
// mtrl_front
// Accepts words, works out prefix length and target level, queues them.
// ----------------------------------------------------------------------------
module mtrl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [31:0]         in_address,
  input  logic [31:0]         in_mask,
  input  logic [31:0]         in_gateway,
  output logic                q_valid,
  output mtrl_pkg::q_word_t   q_word,
  input  logic                q_pop
);

  mtrl_pkg::q_word_t mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push;
  mtrl_pkg::q_word_t cls;
  logic [mtrl_pkg::PLEN_W-1:0] plen;
  logic [mtrl_pkg::LVL_W-1:0]  tgt;
  logic [mtrl_pkg::PLEN_W-1:0] shift_full;

  always_comb begin
    plen = mtrl_pkg::prefix_len(in_mask);
    if (plen <= 6'd16)      tgt = 3'd0;
    else if (plen <= 6'd24) tgt = 3'd1;
    else if (plen <= 6'd28) tgt = 3'd2;
    else if (plen <= 6'd30) tgt = 3'd3;
    else                    tgt = 3'd4;
    shift_full = mtrl_pkg::level_end(tgt) - plen;
    cls.cmd   = in_cmd;
    cls.addr  = in_address;
    cls.gw    = in_gateway;
    cls.plen  = plen;
    cls.tgt   = tgt;
    cls.shift = shift_full[mtrl_pkg::SHIFT_W-1:0];
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= cls;
  end

endmodule

// File: rtl/mtrl_back.sv
// ----------------------------------------------------------------------------
// mtrl_back
// Trie sequencer: clear pass, lookup walk, insert walk and range sweep.
// ----------------------------------------------------------------------------
module mtrl_back #(
  parameter int MAX_NODES = mtrl_pkg::DEF_MAX_NODES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  mtrl_pkg::q_word_t q_word,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_next_hop,
  output logic              out_status
);

  localparam int CW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int PW    = $clog2(MAX_NODES + 1);
  localparam int GW    = mtrl_pkg::GW_W;
  localparam int PL    = mtrl_pkg::PLEN_W;
  localparam int SW    = 2 + PL + GW + CW;
  localparam int AMAX  = (CW + 8 > 16) ? CW + 8 : 16;
  localparam int V_B   = SW - 1;
  localparam int L_B   = SW - 2;
  localparam int P_HI  = SW - 3;
  localparam int G_HI  = CW + GW - 1;
  localparam int NL    = mtrl_pkg::LEVELS;

  mtrl_pkg::bk_state_t st_r, st_nxt;
  logic [AMAX-1:0]     clr_r, clr_nxt;
  logic [2:0]          lvl_r, lvl_nxt;
  logic [CW-1:0]       child_r, child_nxt;
  logic [GW-1:0]       best_r, best_nxt;
  logic [16:0]         cnt_r, cnt_nxt;
  mtrl_pkg::q_word_t   cur_r, cur_nxt;
  logic [AMAX-1:0]     wa_r, wa_nxt;
  logic [PW-1:0]       pool_r [4];
  logic [PW-1:0]       pool_nxt [4];
  logic                out_valid_r, out_valid_nxt;
  logic [GW-1:0]       out_hop_r, out_hop_nxt;
  logic                out_status_r, out_status_nxt;

  logic [SW-1:0]   rdata [NL];
  logic [SW-1:0]   e;
  logic            e_valid, e_linked;
  logic [PL-1:0]   e_plen;
  logic [GW-1:0]   e_gw;
  logic [CW-1:0]   e_child;
  logic            is_lookup, at_tgt, pool_full, last, lookup_done, item_done;
  logic [15:0]     idx, lo, low;
  logic [AMAX-1:0] raddr, waddr;
  logic [SW-1:0]   wdata, wdata_c;
  logic            we_c, clr_mode;
  logic [PW-1:0]   pool_cur;

  // slot RAMs, one per level
  for (genvar l = 0; l < NL; l++) begin : g_lvl
    localparam int ST  = (l == 1) ? 8 : (l == 2) ? 4 : 2;
    localparam int AW  = (l == 0) ? 16 : CW + ST;
    localparam int DEP = (l == 0) ? 65536 : MAX_NODES * (2 ** ST);
    logic we_l;
    assign we_l = clr_mode || (we_c && (lvl_r == 3'(l)));
    mtrl_ram #(.W(SW), .DEPTH(DEP), .AW(AW)) u_ram (
      .clk     (clk),
      .we      (we_l),
      .waddr   (waddr[AW-1:0]),
      .wdata   (wdata),
      .raddr   (raddr[AW-1:0]),
      .rdata_r (rdata[l])
    );
  end

  assign e         = rdata[lvl_r];
  assign e_valid   = e[V_B];
  assign e_linked  = e[L_B];
  assign e_plen    = e[P_HI -: PL];
  assign e_gw      = e[G_HI -: GW];
  assign e_child   = e[CW-1:0];
  assign is_lookup = (cur_r.cmd == mtrl_pkg::CMD_LOOKUP);
  assign at_tgt    = (lvl_r == cur_r.tgt);
  assign idx       = mtrl_pkg::slot_idx(cur_r.addr, lvl_r);
  assign lo        = (idx >> cur_r.shift) << cur_r.shift;
  assign low       = (!is_lookup && at_tgt) ? (lo | cnt_r[15:0]) : idx;
  assign raddr     = (AMAX'(child_r) << mtrl_pkg::stride_of(lvl_r)) | AMAX'(low);
  assign pool_cur  = pool_r[lvl_r[1:0]];
  assign pool_full = (pool_cur >= PW'(MAX_NODES));
  assign last      = (cnt_r == ((17'd1 << cur_r.shift) - 17'd1));
  assign lookup_done = !e_valid || (lvl_r == 3'(NL - 1)) || !e_linked;
  assign clr_mode  = (st_r == mtrl_pkg::ST_CLEAR);
  assign waddr     = clr_mode ? clr_r : wa_r;
  assign wdata     = clr_mode ? '0 : wdata_c;
  assign q_pop     = (st_r == mtrl_pkg::ST_IDLE) && q_valid && (!out_valid_r || out_ready);

  always_comb begin
    if (is_lookup)    item_done = lookup_done;
    else if (!at_tgt) item_done = !e_linked && pool_full;
    else              item_done = last;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      mtrl_pkg::ST_CLEAR: if (clr_r == '1) st_nxt = mtrl_pkg::ST_IDLE;
      mtrl_pkg::ST_IDLE:  if (q_pop) st_nxt = mtrl_pkg::ST_READ;
      mtrl_pkg::ST_READ:  st_nxt = mtrl_pkg::ST_EVAL;
      mtrl_pkg::ST_EVAL:  st_nxt = item_done ? mtrl_pkg::ST_IDLE : mtrl_pkg::ST_READ;
      default:            st_nxt = mtrl_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_nxt        = clr_r;
    lvl_nxt        = lvl_r;
    child_nxt      = child_r;
    best_nxt       = best_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    wa_nxt         = wa_r;
    for (int i = 0; i < 4; i++) pool_nxt[i] = pool_r[i];
    out_valid_nxt  = out_valid_r && !out_ready;
    out_hop_nxt    = out_hop_r;
    out_status_nxt = out_status_r;
    we_c           = 1'b0;
    wdata_c        = '0;
    unique case (st_r)
      mtrl_pkg::ST_CLEAR: clr_nxt = clr_r + AMAX'(1);
      mtrl_pkg::ST_IDLE: begin
        if (q_pop) begin
          cur_nxt   = q_word;
          lvl_nxt   = '0;
          child_nxt = '0;
          best_nxt  = '0;
          cnt_nxt   = '0;
        end
      end
      mtrl_pkg::ST_READ: wa_nxt = raddr;
      mtrl_pkg::ST_EVAL: begin
        if (is_lookup) begin
          if (e_valid && (e_gw != '0)) best_nxt = e_gw;
          if (!lookup_done) begin
            lvl_nxt   = lvl_r + 3'd1;
            child_nxt = e_child;
          end
        end else if (!at_tgt) begin
          if (!e_linked) begin
            if (!pool_full) begin
              we_c    = 1'b1;
              wdata_c = {1'b1, 1'b1, e_valid ? e_plen : PL'(0),
                         e_valid ? e_gw : GW'(0), pool_cur[CW-1:0]};
              pool_nxt[lvl_r[1:0]] = pool_cur + PW'(1);
              child_nxt = pool_cur[CW-1:0];
              lvl_nxt   = lvl_r + 3'd1;
            end
          end else begin
            child_nxt = e_child;
            lvl_nxt   = lvl_r + 3'd1;
          end
        end else begin
          if (!e_valid || (e_plen <= cur_r.plen)) begin
            we_c    = 1'b1;
            wdata_c = {1'b1, e_linked, cur_r.plen, cur_r.gw, e_child};
          end
          cnt_nxt = cnt_r + 17'd1;
        end
        if (item_done) begin
          out_valid_nxt = 1'b1;
          if (is_lookup) begin
            out_hop_nxt    = (e_valid && (e_gw != '0)) ? e_gw : best_r;
            out_status_nxt = mtrl_pkg::STATUS_DONE;
          end else begin
            out_hop_nxt    = '0;
            out_status_nxt = at_tgt ? mtrl_pkg::STATUS_DONE : mtrl_pkg::STATUS_POOL_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= mtrl_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) pool_r[i] <= '0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 4; i++) pool_r[i] <= pool_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    child_r      <= child_nxt;
    best_r       <= best_nxt;
    cnt_r        <= cnt_nxt;
    cur_r        <= cur_nxt;
    wa_r         <= wa_nxt;
    out_hop_r    <= out_hop_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_next_hop = out_hop_r;
  assign out_status   = out_status_r;

endmodule

// File: sim/multibit_trie_route_lookup_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multibit_trie_route_lookup_top_test
// Drives route inserts and address lookups into the trie, predicts every
// result word with a behavioral trie of its own and checks each word field
// by field, under random sender gaps and receiver stalls and also with none.
// ----------------------------------------------------------------------------
module multibit_trie_route_lookup_top_test;

  localparam int NODES = mtrl_pkg::DEF_MAX_NODES;

  typedef struct {
    logic [31:0] gw;
    int          plen;
    bit          valid;
    bit          linked;
    int          child;
  } route_slot_t;

  typedef struct {
    logic [31:0] next_hop;
    logic        status;
  } route_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = mtrl_pkg::CMD_INSERT;
  logic [31:0] in_address = '0;
  logic [31:0] in_mask = '0;
  logic [31:0] in_gateway = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_next_hop;
  logic        out_status;

  // behavioral trie: key is level * 2^24 + slot number
  route_slot_t   trie_slots [longint];
  int            nodes_taken [1:4];
  route_result_t pending_results [$];
  logic [31:0]   known_prefixes [$];
  int            err_count = 0;
  int            send_idle_pct = 0;  // sender gap odds, percent
  int            recv_stall_pct = 0; // receiver stall odds, percent

  multibit_trie_route_lookup_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_address   (in_address),
    .in_mask      (in_mask),
    .in_gateway   (in_gateway),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_next_hop (out_next_hop),
    .out_status   (out_status)
  );

  always #5 clk = ~clk;

  // generous cap: clearing pass, a few full-root expansions, stalls
  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int lvl_stride(int d);
    case (d)
      0: return 16;
      1: return 8;
      2: return 4;
      default: return 2;
    endcase
  endfunction

  function automatic int lvl_low(int d);
    case (d)
      0: return 16;
      1: return 8;
      2: return 4;
      3: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic route_slot_t read_slot(int d, int n);
    route_slot_t z;
    longint k;
    k = longint'(d) * 64'h100_0000 + n;
    z = '{gw: 0, plen: 0, valid: 0, linked: 0, child: 0};
    if (trie_slots.exists(k)) z = trie_slots[k];
    return z;
  endfunction

  function automatic void write_slot(int d, int n, route_slot_t s);
    trie_slots[longint'(d) * 64'h100_0000 + n] = s;
  endfunction

  // insert: descend, take nodes from pools, expand at target level
  function automatic logic route_insert(logic [31:0] a, logic [31:0] m, logic [31:0] g);
    int plen, walk, base, idx, s, sh, lo;
    route_slot_t e;
    plen = 0;
    if (m != 0) begin
      plen = 32;
      for (int i = 31; i >= 0; i--) if (m[i]) plen = 32 - i;
    end
    walk = 0;
    base = 0;
    for (int d = 0; d < 5; d++) begin
      s = lvl_stride(d);
      idx = int'((a >> lvl_low(d)) & ((32'd1 << s) - 1));
      if (walk + s >= plen || d == 4) begin
        sh = walk + s - plen;
        if (sh > s) sh = s;
        lo = (idx >> sh) << sh;
        for (int i = lo; i < lo + (1 << sh); i++) begin
          e = read_slot(d, base + i);
          if (!e.valid || e.plen <= plen) begin
            e.valid = 1;
            e.gw = g;
            e.plen = plen;
            write_slot(d, base + i, e);
          end
        end
        return mtrl_pkg::STATUS_DONE;
      end
      e = read_slot(d, base + idx);
      if (!e.linked) begin
        if (nodes_taken[d + 1] >= NODES) return mtrl_pkg::STATUS_POOL_FULL;
        e.child = nodes_taken[d + 1];
        nodes_taken[d + 1]++;
        e.linked = 1;
      end
      if (!e.valid) begin
        e.valid = 1;
        e.gw = 0;
        e.plen = 0;
      end
      write_slot(d, base + idx, e);
      base = e.child << lvl_stride(d + 1);
      walk += s;
    end
    return mtrl_pkg::STATUS_DONE;
  endfunction

  function automatic logic [31:0] route_lookup(logic [31:0] a);
    logic [31:0] best;
    int base;
    route_slot_t e;
    best = 0;
    base = 0;
    for (int d = 0; d < 5; d++) begin
      e = read_slot(d, base + int'((a >> lvl_low(d)) & ((32'd1 << lvl_stride(d)) - 1)));
      if (!e.valid) return best;
      if (e.gw != 0) best = e.gw;
      if (d == 4 || !e.linked) return best;
      base = e.child << lvl_stride(d + 1);
    end
    return best;
  endfunction

  // mask whose lowest set bit gives the wanted prefix length
  function automatic logic [31:0] mask_for(int plen, bit messy);
    logic [31:0] m;
    if (plen == 0) return 32'h0;
    m = messy ? $urandom : 32'hffff_ffff;
    m = m & (32'hffff_ffff << (32 - plen));
    m[32 - plen] = 1'b1;
    return m;
  endfunction

  // send one word, predict its result at acceptance
  task automatic send_word(logic c, logic [31:0] a, logic [31:0] m, logic [31:0] g);
    route_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_address <= a;
    in_mask    <= m;
    in_gateway <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c == mtrl_pkg::CMD_LOOKUP) begin
      r.next_hop = route_lookup(a);
      r.status = mtrl_pkg::STATUS_DONE;
    end else begin
      r.status = route_insert(a, m, g);
      r.next_hop = 0;
      known_prefixes.push_back(a);
    end
    pending_results.push_back(r);
  endtask

  task automatic send_insert(logic [31:0] a, int plen, logic [31:0] g);
    send_word(mtrl_pkg::CMD_INSERT, a, mask_for(plen, $urandom_range(3) == 0), g);
  endtask

  task automatic send_lookup(logic [31:0] a);
    send_word(mtrl_pkg::CMD_LOOKUP, a, $urandom, $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word next_hop=%h status=%b", $time,
                 out_next_hop, out_status);
        err_count++;
      end else begin
        if (out_next_hop !== pending_results[0].next_hop) begin
          $display("%0t: next_hop expected %h actual %h", $time,
                   pending_results[0].next_hop, out_next_hop);
          err_count++;
        end
        if (out_status !== pending_results[0].status) begin
          $display("%0t: status expected %b actual %b", $time,
                   pending_results[0].status, out_status);
          err_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // edges of fields, zero and full masks, leaf level, zero gateway,
  // non-contiguous mask, cmd both ways
  task automatic test_directed();
    send_lookup(32'h0000_0000);
    send_lookup(32'hffff_ffff);
    send_word(mtrl_pkg::CMD_INSERT, 32'h0, 32'h0, 32'hdead_0001);        // default route
    send_lookup(32'h1234_5678);
    send_word(mtrl_pkg::CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff); // /32
    send_lookup(32'hffff_ffff);
    send_lookup(32'hffff_fffe);
    send_word(mtrl_pkg::CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h0000_0101); // /1
    send_lookup(32'h8000_0001);
    send_word(mtrl_pkg::CMD_INSERT, 32'h0a01_0200, 32'h5a5a_ff00, 32'h0000_0202); // messy /24
    send_lookup(32'h0a01_02ff);
    send_word(mtrl_pkg::CMD_INSERT, 32'h0a01_0280, 32'hffff_ffc0, 32'h0);          // zero gw /26
    send_lookup(32'h0a01_0281);
    send_word(mtrl_pkg::CMD_INSERT, 32'h0a01_0203, 32'hffff_fffe, 32'h0000_0303); // /31 leaf
    send_lookup(32'h0a01_0202);
    send_lookup(32'h0a01_0203);
    send_word(mtrl_pkg::CMD_INSERT, 32'h0a01_0000, 32'hffff_0000, 32'h0000_0404); // /16
    send_lookup(32'h0a01_0203);
    send_lookup(32'h0a01_7777);
    send_word(mtrl_pkg::CMD_INSERT, 32'hc0a8_0000, 32'hfff0_0000, 32'h0000_0505); // /12
    send_lookup(32'hc0af_0001);
    drain();
  endtask

  // exhaust the level-one pool with many distinct /24 routes
  task automatic test_pool_full();
    logic [31:0] a;
    for (int i = 0; i < NODES + 12; i++) begin
      a = {16'h2000 + 16'(i), 8'($urandom), 8'h0};
      send_insert(a, 24, $urandom);
      if (i % 16 == 0) send_lookup(a | 32'($urandom_range(255)));
    end
    send_insert(32'h2fff_0000, 16, 32'h0000_0606); // short prefix still fits
    send_lookup(32'h2fff_1234);
    drain();
  endtask

  // mostly routes inside known prefixes, long prefixes, some noise
  task automatic test_random(int n);
    int plen, pick;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 6 || known_prefixes.size() == 0) a = $urandom;
      else a = known_prefixes[$urandom_range(known_prefixes.size() - 1)]
               ^ ($urandom >> $urandom_range(31, 8));
      if ($urandom_range(99) < 40) begin
        pick = $urandom_range(99);
        if (pick < 70) plen = $urandom_range(32, 17);
        else if (pick < 97) plen = $urandom_range(16, 9);
        else plen = $urandom_range(8, 4);
        send_insert(a, plen, ($urandom_range(19) == 0) ? 32'h0 : $urandom);
      end else begin
        send_lookup(a);
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 16;
    recv_stall_pct = 46;
    test_directed();
    test_pool_full();
    test_random(480);
    send_idle_pct = 46;
    recv_stall_pct = 16;
    test_random(480);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(480);
    if (err_count == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
